FILE: rtl/core/apspj_pkg.sv
`default_nettype none
package apspj_pkg;

  localparam int MAX_NODES_DEF = 32;
  localparam int NODE_FW = 5;
  localparam int NODE_MAX_W = 6;
  localparam int CNT_W = 7;
  localparam int NC_W = 6;
  localparam int WT_W = 16;
  localparam int DIST_W = 32;
  localparam logic [NC_W-1:0] NC_RESET = 6'd32;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NO_POT    = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_EMIT, S_C_INIT,
    S_BF_ROW, S_BF_LDU, S_BF_RD, S_BF_WR,
    S_DJ_SRC, S_DJ_LDS, S_DJ_SCAN0, S_DJ_SRD, S_DJ_SCMP, S_DJ_PICK, S_DJ_LDB,
    S_DJ_RRD, S_DJ_RW, S_DJ_RC, S_DJ_ORD, S_DJ_OWR
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_CLR_WR, OP_ADD, OP_READ, OP_EMIT, OP_C_INIT,
    OP_POT_RD, OP_LD_U, OP_BF_RD, OP_BF_WR,
    OP_DJ_INIT, OP_LD_S, OP_SCAN_INIT, OP_WK_RD, OP_SCMP, OP_PICK, OP_LD_B,
    OP_RLX_RD, OP_RLX_W, OP_RLX_C, OP_OUT_RD, OP_OUT_WR
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [NODE_MAX_W-1:0] a;
    logic [NODE_MAX_W-1:0] b;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] last;
    logic             pv_a;
    logic             best_none;
    logic             out_busy;
    action_t          act;
  } sts_t;

  function automatic logic signed [DIST_W+1:0] sx32(input logic signed [DIST_W-1:0] v);
    return {{2{v[DIST_W-1]}}, v};
  endfunction

  function automatic logic signed [DIST_W+1:0] sx16(input logic signed [WT_W-1:0] v);
    return {{(DIST_W+2-WT_W){v[WT_W-1]}}, v};
  endfunction

  function automatic logic signed [DIST_W-1:0] sat32(input logic signed [DIST_W+1:0] v);
    logic signed [DIST_W+1:0] hi;
    logic signed [DIST_W+1:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[DIST_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/apspj_if.sv
`default_nettype none
interface apspj_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [4:0]  from_node;
  logic [4:0]  to_node;
  logic signed [15:0] weight;
  modport source (output valid, action, from_node, to_node, weight, input ready);
  modport sink (input valid, action, from_node, to_node, weight, output ready);
endinterface

interface apspj_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] distance;
  logic        reachable;
  logic [1:0]  status;
  modport source (output valid, distance, reachable, status, input ready);
  modport sink (input valid, distance, reachable, status, output ready);
endinterface

interface apspj_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/all_pairs_shortest_path_johnson.sv
// All-pairs shortest paths by Johnson's method over up to MAX_NODES nodes.
// in_chan carries one item: clear graph, add edge, compute, or read distance.
// out_chan returns exactly one item per input item, in order.
// cfg_chan writes node_count; it is always ready and marks the results not ready.
// Add edge and read items are decoded, then wait until the output register frees;
// the next item is accepted in the cycle after the result is loaded.
// Clear graph sweeps the edge store, one cell per cycle, over all
// 4**ceil(log2(MAX_NODES)) cells (1024 for 32 nodes).
// Compute runs the potential rounds and then the per-source searches over the
// n nodes in use, bounded by the single read port of each node store.
// After reset the same edge sweep runs before the first item is accepted.
// A stalled receiver holds the result in the output register; a new item is
// still accepted and worked on, and its result waits until the register frees.
`default_nettype none
module all_pairs_shortest_path_johnson #(
  parameter int MAX_NODES = apspj_pkg::MAX_NODES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  apspj_in_if.sink     in_chan,
  apspj_out_if.source  out_chan,
  apspj_cfg_if.sink    cfg_chan
);
  apspj_pkg::cmd_t cmd;
  apspj_pkg::sts_t sts;
  logic in_ready;

  assign in_chan.ready = in_ready;

  apspj_ctl #(.MAX_NODES(MAX_NODES)) u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  apspj_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (in_chan.action),
    .in_from   (in_chan.from_node),
    .in_to     (in_chan.to_node),
    .in_weight (in_chan.weight),
    .out_chan  (out_chan),
    .cfg_chan  (cfg_chan)
  );

endmodule
`default_nettype wire

FILE: rtl/core/apspj_ctl.sv
`default_nettype none
module apspj_ctl #(
  parameter int MAX_NODES = apspj_pkg::MAX_NODES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output apspj_pkg::cmd_t    cmd,
  input  wire apspj_pkg::sts_t sts
);
  localparam int NW = $clog2(MAX_NODES);

  apspj_pkg::state_t state_r, state_nxt;
  logic [NW-1:0] a_r, a_nxt, b_r, b_nxt, r_r, r_nxt;
  logic clr_item_r, clr_item_nxt;
  logic a_last, b_last, r_last;

  assign a_last = (apspj_pkg::CNT_W'(a_r) == sts.last);
  assign b_last = (apspj_pkg::CNT_W'(b_r) == sts.last);
  assign r_last = (apspj_pkg::CNT_W'(r_r) + apspj_pkg::CNT_W'(1) == sts.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= apspj_pkg::S_CLR;
      a_r        <= '0;
      b_r        <= '0;
      r_r        <= '0;
      clr_item_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      a_r        <= a_nxt;
      b_r        <= b_nxt;
      r_r        <= r_nxt;
      clr_item_r <= clr_item_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    r_nxt        = r_r;
    clr_item_nxt = clr_item_r;
    in_ready     = 1'b0;
    cmd.op       = apspj_pkg::OP_NONE;
    cmd.a        = apspj_pkg::NODE_MAX_W'(a_r);
    cmd.b        = apspj_pkg::NODE_MAX_W'(b_r);
    unique case (state_r)
      apspj_pkg::S_CLR: begin
        cmd.op = apspj_pkg::OP_CLR_WR;
        b_nxt  = b_r + NW'(1);
        if (&b_r) begin
          a_nxt = a_r + NW'(1);
          if (&a_r) begin
            state_nxt = clr_item_r ? apspj_pkg::S_EMIT : apspj_pkg::S_IDLE;
          end
        end
      end
      apspj_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = apspj_pkg::OP_LATCH;
          state_nxt = apspj_pkg::S_DEC;
        end
      end
      apspj_pkg::S_DEC: begin
        unique case (sts.act)
          apspj_pkg::ACT_CLEAR: begin
            a_nxt        = '0;
            b_nxt        = '0;
            clr_item_nxt = 1'b1;
            state_nxt    = apspj_pkg::S_CLR;
          end
          apspj_pkg::ACT_ADD: begin
            cmd.op    = apspj_pkg::OP_ADD;
            state_nxt = apspj_pkg::S_EMIT;
          end
          apspj_pkg::ACT_READ: begin
            cmd.op    = apspj_pkg::OP_READ;
            state_nxt = apspj_pkg::S_EMIT;
          end
          default: state_nxt = apspj_pkg::S_C_INIT;
        endcase
      end
      apspj_pkg::S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.op    = apspj_pkg::OP_EMIT;
          state_nxt = apspj_pkg::S_IDLE;
        end
      end
      apspj_pkg::S_C_INIT: begin
        cmd.op    = apspj_pkg::OP_C_INIT;
        r_nxt     = '0;
        a_nxt     = '0;
        state_nxt = apspj_pkg::S_BF_ROW;
      end
      apspj_pkg::S_BF_ROW: begin
        if (sts.pv_a) begin
          cmd.op    = apspj_pkg::OP_POT_RD;
          state_nxt = apspj_pkg::S_BF_LDU;
        end else if (!a_last) begin
          a_nxt = a_r + NW'(1);
        end else if (!r_last) begin
          a_nxt = '0;
          r_nxt = r_r + NW'(1);
        end else begin
          a_nxt     = '0;
          state_nxt = apspj_pkg::S_DJ_SRC;
        end
      end
      apspj_pkg::S_BF_LDU: begin
        cmd.op    = apspj_pkg::OP_LD_U;
        b_nxt     = '0;
        state_nxt = apspj_pkg::S_BF_RD;
      end
      apspj_pkg::S_BF_RD: begin
        cmd.op    = apspj_pkg::OP_BF_RD;
        state_nxt = apspj_pkg::S_BF_WR;
      end
      apspj_pkg::S_BF_WR: begin
        cmd.op = apspj_pkg::OP_BF_WR;
        if (!b_last) begin
          b_nxt     = b_r + NW'(1);
          state_nxt = apspj_pkg::S_BF_RD;
        end else if (!a_last) begin
          a_nxt     = a_r + NW'(1);
          state_nxt = apspj_pkg::S_BF_ROW;
        end else if (!r_last) begin
          a_nxt     = '0;
          r_nxt     = r_r + NW'(1);
          state_nxt = apspj_pkg::S_BF_ROW;
        end else begin
          a_nxt     = '0;
          state_nxt = apspj_pkg::S_DJ_SRC;
        end
      end
      apspj_pkg::S_DJ_SRC: begin
        if (sts.pv_a) begin
          cmd.op    = apspj_pkg::OP_DJ_INIT;
          state_nxt = apspj_pkg::S_DJ_LDS;
        end else if (!a_last) begin
          a_nxt = a_r + NW'(1);
        end else begin
          state_nxt = apspj_pkg::S_EMIT;
        end
      end
      apspj_pkg::S_DJ_LDS: begin
        cmd.op    = apspj_pkg::OP_LD_S;
        state_nxt = apspj_pkg::S_DJ_SCAN0;
      end
      apspj_pkg::S_DJ_SCAN0: begin
        cmd.op    = apspj_pkg::OP_SCAN_INIT;
        b_nxt     = '0;
        state_nxt = apspj_pkg::S_DJ_SRD;
      end
      apspj_pkg::S_DJ_SRD: begin
        cmd.op    = apspj_pkg::OP_WK_RD;
        state_nxt = apspj_pkg::S_DJ_SCMP;
      end
      apspj_pkg::S_DJ_SCMP: begin
        cmd.op = apspj_pkg::OP_SCMP;
        if (b_last) begin
          state_nxt = apspj_pkg::S_DJ_PICK;
        end else begin
          b_nxt     = b_r + NW'(1);
          state_nxt = apspj_pkg::S_DJ_SRD;
        end
      end
      apspj_pkg::S_DJ_PICK: begin
        b_nxt = '0;
        if (sts.best_none) begin
          state_nxt = apspj_pkg::S_DJ_ORD;
        end else begin
          cmd.op    = apspj_pkg::OP_PICK;
          state_nxt = apspj_pkg::S_DJ_LDB;
        end
      end
      apspj_pkg::S_DJ_LDB: begin
        cmd.op    = apspj_pkg::OP_LD_B;
        state_nxt = apspj_pkg::S_DJ_RRD;
      end
      apspj_pkg::S_DJ_RRD: begin
        cmd.op    = apspj_pkg::OP_RLX_RD;
        state_nxt = apspj_pkg::S_DJ_RW;
      end
      apspj_pkg::S_DJ_RW: begin
        cmd.op    = apspj_pkg::OP_RLX_W;
        state_nxt = apspj_pkg::S_DJ_RC;
      end
      apspj_pkg::S_DJ_RC: begin
        cmd.op = apspj_pkg::OP_RLX_C;
        if (b_last) begin
          state_nxt = apspj_pkg::S_DJ_SCAN0;
        end else begin
          b_nxt     = b_r + NW'(1);
          state_nxt = apspj_pkg::S_DJ_RRD;
        end
      end
      apspj_pkg::S_DJ_ORD: begin
        cmd.op    = apspj_pkg::OP_OUT_RD;
        state_nxt = apspj_pkg::S_DJ_OWR;
      end
      apspj_pkg::S_DJ_OWR: begin
        cmd.op = apspj_pkg::OP_OUT_WR;
        if (!b_last) begin
          b_nxt     = b_r + NW'(1);
          state_nxt = apspj_pkg::S_DJ_ORD;
        end else if (!a_last) begin
          a_nxt     = a_r + NW'(1);
          state_nxt = apspj_pkg::S_DJ_SRC;
        end else begin
          state_nxt = apspj_pkg::S_EMIT;
        end
      end
      default: state_nxt = apspj_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/apspj_dp.sv
`default_nettype none
module apspj_dp #(
  parameter int MAX_NODES = apspj_pkg::MAX_NODES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire apspj_pkg::cmd_t cmd,
  output apspj_pkg::sts_t      sts,
  input  wire logic [1:0]      in_action,
  input  wire logic [4:0]      in_from,
  input  wire logic [4:0]      in_to,
  input  wire logic signed [15:0] in_weight,
  apspj_out_if.source          out_chan,
  apspj_cfg_if.sink            cfg_chan
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int NP = 1 << NW;
  localparam int CW = apspj_pkg::CNT_W;

  typedef logic [NW-1:0] node_t;
  typedef logic [2*NW-1:0] cell_t;

  // Configuration and result flag.
  logic [apspj_pkg::NC_W-1:0] nc_r;
  logic rr_r;
  logic [CW-1:0] eff, last;
  node_t last_node;

  // Latched item.
  apspj_pkg::action_t act_r;
  logic [4:0] from_r, to_r;
  logic signed [15:0] wt_r;
  apspj_pkg::status_t st_r;

  // Stores. Edge word is {present, weight}; pair word is {reachable, distance}.
  logic [16:0] edge_mem [NP*NP];
  logic [16:0] e_rd_r;
  logic signed [31:0] pot_mem [NP];
  logic signed [31:0] pot_rd_r;
  logic signed [31:0] work_mem [NP];
  logic signed [31:0] wk_rd_r;
  logic [32:0] pair_mem [NP*NP];
  logic [32:0] pair_rd_r;

  logic [NP-1:0] pv_r, reach_r, vis_r;
  logic signed [31:0] pot_u_r, pot_s_r, pot_b_r, best_d_r, rw_w_r;
  node_t best_r;
  logic best_none_r, rw_ok_r;

  logic ov_r, orch_r;
  logic signed [31:0] od_r;
  apspj_pkg::status_t ost_r;

  node_t na, nb, nf, nt;
  logic range_bad;
  apspj_pkg::status_t rd_st;
  logic signed [31:0] bf_c, rlx_w, rlx_c, out_v;
  logic bf_upd, rlx_upd, scan_take;

  logic e_we, e_re, p_we, p_re, w_we, w_re, pr_we, pr_re;
  cell_t e_wa, e_ra, pr_wa, pr_ra;
  node_t p_wa, p_ra, w_wa, w_ra;
  logic [16:0] e_wd;
  logic signed [31:0] p_wd, w_wd;
  logic [32:0] pr_wd;

  assign na = node_t'(cmd.a);
  assign nb = node_t'(cmd.b);
  assign nf = node_t'(from_r);
  assign nt = node_t'(to_r);

  always_comb begin
    if (nc_r < apspj_pkg::NC_W'(2)) begin
      eff = CW'(2);
    end else if (CW'(nc_r) > CW'(MAX_NODES)) begin
      eff = CW'(MAX_NODES);
    end else begin
      eff = CW'(nc_r);
    end
  end
  assign last      = eff - CW'(1);
  assign last_node = node_t'(last);

  assign range_bad = (CW'(from_r) >= eff) || (CW'(to_r) >= eff);

  always_comb begin
    if (!rr_r) begin
      rd_st = apspj_pkg::ST_NOT_READY;
    end else if (range_bad) begin
      rd_st = apspj_pkg::ST_RANGE;
    end else if (!pv_r[nf] || !pv_r[nt]) begin
      rd_st = apspj_pkg::ST_NO_POT;
    end else begin
      rd_st = apspj_pkg::ST_OK;
    end
  end

  assign bf_c  = apspj_pkg::sat32(apspj_pkg::sx32(pot_u_r) + apspj_pkg::sx16(e_rd_r[15:0]));
  assign bf_upd = e_rd_r[16] && pv_r[na] && (!pv_r[nb] || bf_c < pot_rd_r);

  assign rlx_w = apspj_pkg::sat32(apspj_pkg::sx16(e_rd_r[15:0]) + apspj_pkg::sx32(pot_b_r)
                                  - apspj_pkg::sx32(pot_rd_r));
  assign rlx_c = apspj_pkg::sat32(apspj_pkg::sx32(best_d_r) + apspj_pkg::sx32(rw_w_r));
  assign rlx_upd = rw_ok_r && (!reach_r[nb] || rlx_c < wk_rd_r);

  assign out_v = apspj_pkg::sat32(apspj_pkg::sx32(wk_rd_r) - apspj_pkg::sx32(pot_s_r)
                                  + apspj_pkg::sx32(pot_rd_r));

  // Strict compare over ascending index keeps the lowest index on ties.
  assign scan_take = !vis_r[nb] && reach_r[nb] && (best_none_r || wk_rd_r < best_d_r);

  always_comb begin
    e_we = 1'b0; e_re = 1'b0; p_we = 1'b0; p_re = 1'b0;
    w_we = 1'b0; w_re = 1'b0; pr_we = 1'b0; pr_re = 1'b0;
    e_wa = {na, nb}; e_ra = {na, nb}; e_wd = '0;
    p_wa = nb; p_ra = nb; p_wd = bf_c;
    w_wa = nb; w_ra = nb; w_wd = rlx_c;
    pr_wa = {na, nb}; pr_ra = {nf, nt};
    pr_wd = reach_r[nb] ? {1'b1, out_v} : 33'd0;
    case (cmd.op)
      apspj_pkg::OP_CLR_WR: e_we = 1'b1;
      apspj_pkg::OP_ADD: begin
        e_we = !range_bad;
        e_wa = {nf, nt};
        e_wd = {1'b1, wt_r};
      end
      apspj_pkg::OP_READ: pr_re = 1'b1;
      apspj_pkg::OP_C_INIT: begin
        p_we = 1'b1;
        p_wa = last_node;
        p_wd = '0;
      end
      apspj_pkg::OP_POT_RD: begin
        p_re = 1'b1;
        p_ra = na;
      end
      apspj_pkg::OP_BF_RD: begin
        e_re = 1'b1;
        p_re = 1'b1;
      end
      apspj_pkg::OP_BF_WR: p_we = bf_upd;
      apspj_pkg::OP_DJ_INIT: begin
        w_we = 1'b1;
        w_wa = na;
        w_wd = '0;
        p_re = 1'b1;
        p_ra = na;
      end
      apspj_pkg::OP_WK_RD: w_re = 1'b1;
      apspj_pkg::OP_PICK: begin
        p_re = 1'b1;
        p_ra = best_r;
      end
      apspj_pkg::OP_RLX_RD: begin
        e_re = 1'b1;
        e_ra = {best_r, nb};
        p_re = 1'b1;
        w_re = 1'b1;
      end
      apspj_pkg::OP_RLX_C: w_we = rlx_upd;
      apspj_pkg::OP_OUT_RD: begin
        p_re = 1'b1;
        w_re = 1'b1;
      end
      apspj_pkg::OP_OUT_WR: pr_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) edge_mem[e_wa] <= e_wd;
    if (e_re) e_rd_r <= edge_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we) pot_mem[p_wa] <= p_wd;
    if (p_re) pot_rd_r <= pot_mem[p_ra];
  end

  always_ff @(posedge clk) begin
    if (w_we) work_mem[w_wa] <= w_wd;
    if (w_re) wk_rd_r <= work_mem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (pr_we) pair_mem[pr_wa] <= pr_wd;
    if (pr_re) pair_rd_r <= pair_mem[pr_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r        <= apspj_pkg::NC_RESET;
      rr_r        <= 1'b0;
      pv_r        <= '0;
      reach_r     <= '0;
      vis_r       <= '0;
      best_none_r <= 1'b1;
      ov_r        <= 1'b0;
    end else begin
      case (cmd.op)
        apspj_pkg::OP_C_INIT: begin
          pv_r <= {{(NP-1){1'b0}}, 1'b1} << last_node;
          rr_r <= 1'b1;
        end
        apspj_pkg::OP_BF_WR: if (bf_upd) pv_r[nb] <= 1'b1;
        apspj_pkg::OP_DJ_INIT: begin
          reach_r <= {{(NP-1){1'b0}}, 1'b1} << na;
          vis_r   <= '0;
        end
        apspj_pkg::OP_SCAN_INIT: best_none_r <= 1'b1;
        apspj_pkg::OP_SCMP: if (scan_take) best_none_r <= 1'b0;
        apspj_pkg::OP_PICK: vis_r[best_r] <= 1'b1;
        apspj_pkg::OP_RLX_C: if (rlx_upd) reach_r[nb] <= 1'b1;
        default: ;
      endcase
      if (cfg_chan.valid) begin
        nc_r <= cfg_chan.data;
        rr_r <= 1'b0;
      end
      if (cmd.op == apspj_pkg::OP_EMIT) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      apspj_pkg::OP_LATCH: begin
        act_r  <= apspj_pkg::action_t'(in_action);
        from_r <= in_from;
        to_r   <= in_to;
        wt_r   <= in_weight;
        st_r   <= apspj_pkg::ST_OK;
      end
      apspj_pkg::OP_ADD: if (range_bad) st_r <= apspj_pkg::ST_RANGE;
      apspj_pkg::OP_READ: st_r <= rd_st;
      apspj_pkg::OP_LD_U: pot_u_r <= pot_rd_r;
      // A self-loop update changes the row's own potential for later columns.
      apspj_pkg::OP_BF_WR: if (bf_upd && nb == na) pot_u_r <= bf_c;
      apspj_pkg::OP_LD_S: pot_s_r <= pot_rd_r;
      apspj_pkg::OP_SCMP: begin
        if (scan_take) begin
          best_r   <= nb;
          best_d_r <= wk_rd_r;
        end
      end
      apspj_pkg::OP_LD_B: pot_b_r <= pot_rd_r;
      apspj_pkg::OP_RLX_W: begin
        rw_w_r  <= rlx_w;
        rw_ok_r <= e_rd_r[16] && pv_r[nb];
      end
      apspj_pkg::OP_RLX_C: if (rlx_upd && nb == best_r) best_d_r <= rlx_c;
      apspj_pkg::OP_EMIT: begin
        ost_r <= st_r;
        if (act_r == apspj_pkg::ACT_READ && st_r == apspj_pkg::ST_OK && pair_rd_r[32]) begin
          od_r   <= pair_rd_r[31:0];
          orch_r <= 1'b1;
        end else begin
          od_r   <= '0;
          orch_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign sts.last      = last;
  assign sts.pv_a      = pv_r[na];
  assign sts.best_none = best_none_r;
  assign sts.out_busy  = ov_r && !out_chan.ready;
  assign sts.act       = act_r;

  assign out_chan.valid     = ov_r;
  assign out_chan.distance  = od_r;
  assign out_chan.reachable = orch_r;
  assign out_chan.status    = ost_r;
  assign cfg_chan.ready     = 1'b1;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == apspj_pkg::OP_EMIT |-> !(ov_r && !out_chan.ready))
    else $error("result loaded over a pending item");

  a_src_pot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == apspj_pkg::OP_C_INIT |=> pv_r[$past(last_node)])
    else $error("potential source not marked valid");

  a_pick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == apspj_pkg::OP_PICK |-> !best_none_r && reach_r[best_r] && !vis_r[best_r])
    else $error("picked node is not a reached unvisited node");

endmodule
`default_nettype wire
